// ===== design/ubx_frame_deframer_top_defines.svh =====
// Assertion macros used by the deframer RTL
`ifndef UBX_FRAME_DEFRAMER_TOP_DEFINES_SVH
`define UBX_FRAME_DEFRAMER_TOP_DEFINES_SVH

// Same-cycle implication, checked on clk, off while in reset
`define UFD_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, checked on clk, off while in reset
`define UFD_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

// ===== design/ubx_fd_pkg.sv =====
// Shared types and constants for the frame deframer
package ubx_fd_pkg;

  // Frame limits and layout
  localparam int unsigned MAX_PAYLOAD = 512;
  localparam int unsigned POS_W       = 10;
  localparam int unsigned LEN_W       = 10;
  localparam int unsigned IDX_W       = 9;
  localparam int unsigned HDR_LEN     = 6;

  // Result queue depth
  localparam int unsigned QUEUE_DEPTH = 4;
  localparam int unsigned QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int unsigned QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  // Configuration register indexes
  localparam logic REG_SYNC_FIRST  = 1'b0;
  localparam logic REG_SYNC_SECOND = 1'b1;

  // Reset values of the sync registers
  localparam logic [7:0] SYNC_FIRST_RST  = 8'd181;
  localparam logic [7:0] SYNC_SECOND_RST = 8'd98;

  // Result kinds
  localparam logic KIND_PAYLOAD = 1'b0;
  localparam logic KIND_VERDICT = 1'b1;

  // Verdict status codes
  typedef enum logic [2:0] {
    ST_OK       = 3'd0,
    ST_BAD_SYNC = 3'd1,
    ST_TOO_LONG = 3'd2,
    ST_TRUNC    = 3'd3,
    ST_CSUM     = 3'd4
  } status_t;

  // One result word
  typedef struct packed {
    logic             item_kind;
    logic [7:0]       payload_byte;
    logic [IDX_W-1:0] payload_index;
    logic [7:0]       msg_class;
    logic [7:0]       msg_id;
    logic [LEN_W-1:0] payload_len;
    status_t          status;
  } result_t;

endpackage

// ===== design/ubx_fd_front.sv =====
// Front end: sync/header parser, 8-bit Fletcher checksum and result classification
module ubx_fd_front import ubx_fd_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       cfg_we,
  input  logic       cfg_index,
  input  logic [7:0] cfg_wdata,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] in_rx_byte,
  input  logic       in_buf_last,
  input  logic       q_full,
  output logic       q_push,
  output result_t    q_wdata
);

  logic [7:0]       sync_first_r, sync_second_r;
  logic [POS_W-1:0] pos_r, pos_nxt;
  logic [7:0]       sum_a_r, sum_a_nxt;
  logic [7:0]       sum_b_r, sum_b_nxt;
  logic [7:0]       class_r, class_nxt;
  logic [7:0]       id_r, id_nxt;
  logic [LEN_W-1:0] len_r, len_nxt;
  logic             verdict_r;

  logic             acc;
  logic             hit;
  logic             fwd;
  logic             add;
  status_t          st;
  logic [15:0]      len_full;
  logic [POS_W-1:0] len_end;
  logic [POS_W-1:0] idx_full;

  assign in_stall = q_full;
  assign acc      = in_valid && !in_stall;
  assign len_end  = len_r + POS_W'(HDR_LEN);
  assign idx_full = pos_r - POS_W'(HDR_LEN);
  assign len_full = {in_rx_byte, len_r[7:0]};

  // Classify the current word by its position in the frame
  always_comb begin
    hit       = 1'b0;
    fwd       = 1'b0;
    add       = 1'b0;
    st        = ST_OK;
    class_nxt = class_r;
    id_nxt    = id_r;
    len_nxt   = len_r;
    if (!verdict_r) begin
      if (pos_r == POS_W'(0)) begin
        if (in_rx_byte != sync_first_r) begin
          hit = 1'b1;
          st  = ST_BAD_SYNC;
        end
      end else if (pos_r == POS_W'(1)) begin
        if (in_rx_byte != sync_second_r) begin
          hit = 1'b1;
          st  = ST_BAD_SYNC;
        end
      end else if (pos_r == POS_W'(2)) begin
        class_nxt = in_rx_byte;
        add       = 1'b1;
      end else if (pos_r == POS_W'(3)) begin
        id_nxt = in_rx_byte;
        add    = 1'b1;
      end else if (pos_r == POS_W'(4)) begin
        len_nxt = {2'b00, in_rx_byte};
        add     = 1'b1;
      end else if (pos_r == POS_W'(5)) begin
        len_nxt = len_full[LEN_W-1:0];
        add     = 1'b1;
        if (len_full > 16'(MAX_PAYLOAD)) begin
          hit = 1'b1;
          st  = ST_TOO_LONG;
        end
      end else if (pos_r < len_end) begin
        add = 1'b1;
        fwd = 1'b1;
      end else if (pos_r == len_end) begin
        if (in_rx_byte != sum_a_r) begin
          hit = 1'b1;
          st  = ST_CSUM;
        end
      end else begin
        hit = 1'b1;
        st  = (in_rx_byte != sum_b_r) ? ST_CSUM : ST_OK;
      end
      // Buffer ended before the frame did
      if (!hit && in_buf_last) begin
        hit = 1'b1;
        st  = ST_TRUNC;
      end
    end
  end

  // Running checksum and position
  always_comb begin
    sum_a_nxt = add ? (sum_a_r + in_rx_byte) : sum_a_r;
    sum_b_nxt = add ? (sum_b_r + sum_a_nxt) : sum_b_r;
    pos_nxt   = pos_r + POS_W'(1);
  end

  // Result word toward the queue
  always_comb begin
    q_push                = acc && !verdict_r && (hit || fwd);
    q_wdata.item_kind     = hit ? KIND_VERDICT : KIND_PAYLOAD;
    q_wdata.payload_byte  = hit ? 8'd0 : in_rx_byte;
    q_wdata.payload_index = hit ? IDX_W'(0) : idx_full[IDX_W-1:0];
    q_wdata.msg_class     = class_nxt;
    q_wdata.msg_id        = id_nxt;
    q_wdata.payload_len   = (hit && st == ST_OK) ? len_r : LEN_W'(0);
    q_wdata.status        = hit ? st : ST_OK;
  end

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sync_first_r  <= SYNC_FIRST_RST;
      sync_second_r <= SYNC_SECOND_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_SYNC_FIRST:  sync_first_r  <= cfg_wdata;
        REG_SYNC_SECOND: sync_second_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // Frame state; cleared at every buffer end
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r     <= '0;
      sum_a_r   <= '0;
      sum_b_r   <= '0;
      class_r   <= '0;
      id_r      <= '0;
      len_r     <= '0;
      verdict_r <= 1'b0;
    end else if (acc) begin
      if (in_buf_last) begin
        pos_r     <= '0;
        sum_a_r   <= '0;
        sum_b_r   <= '0;
        class_r   <= '0;
        id_r      <= '0;
        len_r     <= '0;
        verdict_r <= 1'b0;
      end else if (!verdict_r) begin
        if (hit) begin
          verdict_r <= 1'b1;
        end else begin
          pos_r   <= pos_nxt;
          sum_a_r <= sum_a_nxt;
          sum_b_r <= sum_b_nxt;
          class_r <= class_nxt;
          id_r    <= id_nxt;
          len_r   <= len_nxt;
        end
      end
    end
  end

endmodule

// ===== design/ubx_fd_queue.sv =====
// Short result queue between parser and output stage
module ubx_fd_queue import ubx_fd_pkg::*; (
  input  logic    clk,
  input  logic    rst_n,
  input  logic    push,
  input  result_t wdata,
  output logic    full,
  input  logic    pop,
  output logic    not_empty,
  output result_t rdata
);

`include "ubx_frame_deframer_top_defines.svh"

  result_t           mem [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [QCNT_W-1:0] count_r, count_nxt;

  assign full      = (count_r == QCNT_W'(QUEUE_DEPTH));
  assign not_empty = (count_r != QCNT_W'(0));
  assign rdata     = mem[rd_ptr_r];

  always_comb begin
    count_nxt = count_r;
    if (push && !pop) count_nxt = count_r + QCNT_W'(1);
    else if (pop && !push) count_nxt = count_r - QCNT_W'(1);
  end

  // Storage
  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr_r] <= wdata;
    end
  end

  // Pointers and fill count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) wr_ptr_r <= wr_ptr_r + QPTR_W'(1);
      if (pop)  rd_ptr_r <= rd_ptr_r + QPTR_W'(1);
      count_r <= count_nxt;
    end
  end

  `UFD_ASSERT_NOW(a_no_overflow, push, !full, "push into full queue")
  `UFD_ASSERT_NOW(a_no_underflow, pop, not_empty, "pop from empty queue")
  `UFD_ASSERT_NOW(a_count_range, 1'b1, count_r <= QCNT_W'(QUEUE_DEPTH), "queue count out of range")
  `UFD_ASSERT_NEXT(a_count_inc, push && !pop, count_r == $past(count_r) + QCNT_W'(1), "count did not advance")

endmodule

// ===== design/ubx_fd_back.sv =====
// Back end: output register fed from the result queue
module ubx_fd_back import ubx_fd_pkg::*; (
  input  logic    clk,
  input  logic    rst_n,
  input  logic    q_not_empty,
  input  result_t q_rdata,
  output logic    q_pop,
  output logic    out_valid,
  input  logic    out_stall,
  output result_t out_data
);

  logic    out_valid_r;
  result_t out_data_r;

  // Load a new word whenever the register is empty or being taken
  assign q_pop     = q_not_empty && (!out_valid_r || !out_stall);
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (!out_valid_r || !out_stall) begin
      out_valid_r <= q_not_empty;
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      out_data_r <= q_rdata;
    end
  end

endmodule

// ===== design/ubx_frame_deframer_top.sv =====
// Top level of the UBX-style frame deframer
// Takes one buffer byte per cycle and checks sync, header, length and the
// Fletcher-16 checksum as the bytes stream through. Payload bytes come out
// as they arrive, followed by one verdict word per buffer; drop the payload
// when the verdict status is not ok. A byte is accepted every cycle unless
// the four-word result queue is full; a result word is written into the queue
// and then into the output register before it shows at the output. The input
// stalls only when the output side holds stall long enough to fill that queue.
module ubx_frame_deframer_top import ubx_fd_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             cfg_we,
  input  logic             cfg_index,
  input  logic [7:0]       cfg_wdata,
  input  logic             in_valid,
  output logic             in_stall,
  input  logic [7:0]       in_rx_byte,
  input  logic             in_buf_last,
  output logic             out_valid,
  input  logic             out_stall,
  output logic             out_item_kind,
  output logic [7:0]       out_payload_byte,
  output logic [IDX_W-1:0] out_payload_index,
  output logic [7:0]       out_msg_class,
  output logic [7:0]       out_msg_id,
  output logic [LEN_W-1:0] out_payload_len,
  output logic [2:0]       out_status
);

  logic    q_push, q_full, q_pop, q_not_empty;
  result_t q_wdata, q_rdata, out_data;

  ubx_fd_front u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_we      (cfg_we),
    .cfg_index   (cfg_index),
    .cfg_wdata   (cfg_wdata),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .in_rx_byte  (in_rx_byte),
    .in_buf_last (in_buf_last),
    .q_full      (q_full),
    .q_push      (q_push),
    .q_wdata     (q_wdata)
  );

  ubx_fd_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .wdata     (q_wdata),
    .full      (q_full),
    .pop       (q_pop),
    .not_empty (q_not_empty),
    .rdata     (q_rdata)
  );

  ubx_fd_back u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .q_not_empty (q_not_empty),
    .q_rdata     (q_rdata),
    .q_pop       (q_pop),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .out_data    (out_data)
  );

  // Split the result word onto its ports
  assign out_item_kind     = out_data.item_kind;
  assign out_payload_byte  = out_data.payload_byte;
  assign out_payload_index = out_data.payload_index;
  assign out_msg_class     = out_data.msg_class;
  assign out_msg_id        = out_data.msg_id;
  assign out_payload_len   = out_data.payload_len;
  assign out_status        = out_data.status;

endmodule
